// ===== src/assert_macros.svh =====
// Assertion macros shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-cycle property, clocked on clk, off while rst_n is low.
`define SBQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define SBQ_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== src/sbq_pkg.sv =====
// Shared constants, codes and command type of the stereo biquad filter.
package sbq_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int NUM_COEF       = 5;
    localparam int CFG_IDX_W      = 3;
    localparam int COEF_WIDTH_DEF = 32;
    localparam int HIST_WIDTH_DEF = 32;

    // Tap / coefficient register codes
    localparam logic [CFG_IDX_W-1:0] TAP_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] TAP_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] TAP_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] TAP_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] TAP_A2 = 3'd4;

    // Sequencer step numbering
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] CH1_STEP     = 4'd5;
    localparam logic [STEP_W-1:0] LOAD0_STEP   = 4'd1;
    localparam logic [STEP_W-1:0] LOAD1_STEP   = 4'd6;
    localparam logic [STEP_W-1:0] COMMIT0_STEP = 4'd6;
    localparam logic [STEP_W-1:0] MUL_LAST     = 4'd9;
    localparam logic [STEP_W-1:0] LAST_STEP    = 4'd11;

    typedef struct packed {
        logic                 load_in;   // latch the new sample pair
        logic                 mul_en;    // issue one product
        logic [CFG_IDX_W-1:0] mul_tap;   // which tap the product is for
        logic                 mul_ch;    // 0 left, 1 right
        logic                 acc_load;  // accumulator takes the first term
        logic                 acc_add;   // accumulator adds the next term
        logic                 commit;    // store result, shift channel history
        logic                 commit_ch; // channel being committed
    } cmd_t;

endpackage

// ===== src/sbq_ctrl.sv =====
// Sequencer for the shared-multiplier biquad datapath and stream handshakes.
module sbq_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output sbq_pkg::cmd_t cmd
);
    import sbq_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic              state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              run, at_last, commit_ok, accept;
    logic [STEP_W-1:0] tap_cnt;

    always_comb
    begin
        run       = (state_reg == ST_RUN);
        at_last   = run && (step_reg == LAST_STEP);
        commit_ok = !out_valid_reg || m_ready;
        s_ready   = !run || (at_last && commit_ok);
        accept    = s_valid && s_ready;
        tap_cnt   = (step_reg < CH1_STEP) ? step_reg : step_reg - CH1_STEP;

        cmd.load_in   = accept;
        cmd.mul_en    = run && (step_reg <= MUL_LAST);
        cmd.mul_tap   = tap_cnt[CFG_IDX_W-1:0];
        cmd.mul_ch    = (step_reg >= CH1_STEP);
        cmd.acc_load  = run && ((step_reg == LOAD0_STEP) || (step_reg == LOAD1_STEP));
        cmd.acc_add   = run && (((step_reg > LOAD0_STEP) && (step_reg <= CH1_STEP)) ||
                                ((step_reg > LOAD1_STEP) && (step_reg < LAST_STEP)));
        cmd.commit    = run && ((step_reg == COMMIT0_STEP) || (at_last && commit_ok));
        cmd.commit_ch = (step_reg == LAST_STEP);

        m_valid = out_valid_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                if (at_last)
                begin
                    if (commit_ok)
                    begin
                        step_next  = '0;
                        state_next = accept ? ST_RUN : ST_IDLE;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (at_last && commit_ok)
            out_valid_next = 1'b1;
        else if (m_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/sbq_datapath.sv =====
// Coefficients, channel history, shared multiplier, accumulator and output scaling.
module sbq_datapath
#(
    parameter int COEF_WIDTH    = sbq_pkg::COEF_WIDTH_DEF,
    parameter int HISTORY_WIDTH = sbq_pkg::HIST_WIDTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [sbq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [COEF_WIDTH-1:0]              cfg_data,
    input  sbq_pkg::cmd_t                      cmd,
    input  logic signed [sbq_pkg::SAMPLE_W-1:0] left_in,
    input  logic signed [sbq_pkg::SAMPLE_W-1:0] right_in,
    output logic signed [sbq_pkg::SAMPLE_W-1:0] left_out,
    output logic signed [sbq_pkg::SAMPLE_W-1:0] right_out
);
    import sbq_pkg::*;

    localparam int CW     = COEF_WIDTH;
    localparam int HW     = HISTORY_WIDTH;
    localparam int PROD_W = CW + HW;
    localparam int TERM_W = HW + 4;
    localparam int ACC_W  = HW + 6;

    localparam logic signed [CW-1:0] B0_RESET = {3'b000, 1'b1, {(CW-4){1'b0}}};
    localparam logic signed [ACC_W-1:0] HIST_MAX =
        {{(ACC_W-HW+1){1'b0}}, {(HW-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] HIST_MIN = ~HIST_MAX;
    localparam logic [ACC_W-1:0] CLIP_U = {{(ACC_W-HW+4){1'b0}}, 1'b1, {(HW-5){1'b0}}};
    localparam logic [HW-5:0]    MAG_ONE = {1'b1, {(HW-5){1'b0}}};

    logic signed [CW-1:0]       coef_reg [NUM_COEF];
    logic signed [SAMPLE_W-1:0] x_reg    [2];
    logic signed [SAMPLE_W-1:0] xh1_reg  [2];
    logic signed [SAMPLE_W-1:0] xh2_reg  [2];
    logic signed [HW-1:0]       yh1_reg  [2];
    logic signed [HW-1:0]       yh2_reg  [2];

    logic signed [PROD_W-1:0]   prod_reg;
    logic                       prod_sub_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [SAMPLE_W-1:0] res_l_reg;
    logic signed [SAMPLE_W-1:0] out_l_reg, out_r_reg;

    logic signed [CW-1:0]       coef_sel;
    logic signed [HW-1:0]       opnd_sel;
    logic signed [TERM_W-1:0]   term;
    logic signed [ACC_W-1:0]    term_ext;
    logic signed [ACC_W-1:0]    sat;
    logic                       neg;
    logic [ACC_W-1:0]           abs_acc;
    logic [HW-5:0]              mag;
    logic [HW+10:0]             scaled;
    logic [SAMPLE_W-1:0]        q;
    logic signed [SAMPLE_W-1:0] res;

    // Sample as Q4.(HW-5): x * 2^(HW-20)
    function automatic logic signed [HW-1:0] to_hist(input logic signed [SAMPLE_W-1:0] x);
        to_hist = {{4{x[SAMPLE_W-1]}}, x, {(HW-20){1'b0}}};
    endfunction

    // Operand select
    always_comb
    begin
        case (cmd.mul_tap)
            TAP_B0:
            begin
                coef_sel = coef_reg[TAP_B0];
                opnd_sel = to_hist(x_reg[cmd.mul_ch]);
            end
            TAP_B1:
            begin
                coef_sel = coef_reg[TAP_B1];
                opnd_sel = to_hist(xh1_reg[cmd.mul_ch]);
            end
            TAP_B2:
            begin
                coef_sel = coef_reg[TAP_B2];
                opnd_sel = to_hist(xh2_reg[cmd.mul_ch]);
            end
            TAP_A1:
            begin
                coef_sel = coef_reg[TAP_A1];
                opnd_sel = yh1_reg[cmd.mul_ch];
            end
            TAP_A2:
            begin
                coef_sel = coef_reg[TAP_A2];
                opnd_sel = yh2_reg[cmd.mul_ch];
            end
            default:
            begin
                coef_sel = coef_reg[TAP_B0];
                opnd_sel = to_hist(x_reg[cmd.mul_ch]);
            end
        endcase
    end

    // Product scaled by 2^-(CW-4), floor; feedback taps are subtracted
    always_comb
    begin
        term     = prod_reg[PROD_W-1:CW-4];
        term_ext = {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
        if (cmd.acc_load)
            acc_next = prod_sub_reg ? -term_ext : term_ext;
        else if (cmd.acc_add)
            acc_next = prod_sub_reg ? acc_reg - term_ext : acc_reg + term_ext;
        else
            acc_next = acc_reg;
    end

    // Saturate for history; clip to +-1, scale by 32767, truncate toward zero
    always_comb
    begin
        if (acc_reg > HIST_MAX)
            sat = HIST_MAX;
        else if (acc_reg < HIST_MIN)
            sat = HIST_MIN;
        else
            sat = acc_reg;

        neg     = acc_reg[ACC_W-1];
        abs_acc = neg ? -acc_reg : acc_reg;
        mag     = (abs_acc > CLIP_U) ? MAG_ONE : abs_acc[HW-5:0];
        scaled  = {mag, 15'b0} - {15'b0, mag};
        q       = scaled[HW+10:HW-5];
        res     = neg ? -q : q;
    end

    // Coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[TAP_B0] <= B0_RESET;
            coef_reg[TAP_B1] <= '0;
            coef_reg[TAP_B2] <= '0;
            coef_reg[TAP_A1] <= '0;
            coef_reg[TAP_A2] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                TAP_B0:  coef_reg[TAP_B0] <= cfg_data;
                TAP_B1:  coef_reg[TAP_B1] <= cfg_data;
                TAP_B2:  coef_reg[TAP_B2] <= cfg_data;
                TAP_A1:  coef_reg[TAP_A1] <= cfg_data;
                TAP_A2:  coef_reg[TAP_A2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Per-channel filter history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                xh1_reg[i] <= '0;
                xh2_reg[i] <= '0;
                yh1_reg[i] <= '0;
                yh2_reg[i] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            xh2_reg[cmd.commit_ch] <= xh1_reg[cmd.commit_ch];
            xh1_reg[cmd.commit_ch] <= x_reg[cmd.commit_ch];
            yh2_reg[cmd.commit_ch] <= yh1_reg[cmd.commit_ch];
            yh1_reg[cmd.commit_ch] <= sat[HW-1:0];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x_reg[0] <= left_in;
            x_reg[1] <= right_in;
        end
        if (cmd.mul_en)
        begin
            prod_reg     <= coef_sel * opnd_sel;
            prod_sub_reg <= (cmd.mul_tap == TAP_A1) || (cmd.mul_tap == TAP_A2);
        end
        acc_reg <= acc_next;
        if (cmd.commit && !cmd.commit_ch)
            res_l_reg <= res;
        if (cmd.commit && cmd.commit_ch)
        begin
            out_l_reg <= res_l_reg;
            out_r_reg <= res;
        end
    end

    assign left_out  = out_l_reg;
    assign right_out = out_r_reg;

endmodule

// ===== src/stereo_biquad_shelf_filter.sv =====
// Top level of the stereo direct-form-I biquad (shelf) filter.

// Stereo biquad: each item is a pair of 16-bit PCM samples, and both channels run through
// the same five Q4.(COEF_WIDTH-4) coefficients, y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2,
// with the unclipped output kept in Q4.(HISTORY_WIDTH-5) and saturated at +-16. The
// delivered result is y clipped to +-1, times 32767, truncated toward zero. One signed
// multiplier is shared by all ten products of an item: five taps per channel, one product
// per cycle, with the right channel's products overlapping the left channel's final add
// and commit. A new item is taken in the last step of the sequence, as the right channel
// commits, so items follow back to back as long as the output side keeps up. A finished
// pair waits in an output register while the next item is being filtered; the filter only
// stalls at its last step if the previous result has still not been taken. Coefficients
// are written through cfg_we/cfg_index/cfg_data (0 b0, 1 b1, 2 b2, 3 a1, 4 a2; other
// indexes are ignored) and must only be changed while the filter is idle. Reset sets b0
// to 1.0, the rest to zero, and clears the sample history.
module stereo_biquad_shelf_filter
#(
    parameter int COEF_WIDTH    = sbq_pkg::COEF_WIDTH_DEF,
    parameter int HISTORY_WIDTH = sbq_pkg::HIST_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [2*sbq_pkg::SAMPLE_W-1:0] s_axis_tdata,  // [15:0] left_in, [31:16] right_in
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [2*sbq_pkg::SAMPLE_W-1:0] m_axis_tdata,  // [15:0] left_out, [31:16] right_out
    // coefficient write port
    input  logic                          cfg_we,
    input  logic [sbq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_WIDTH-1:0]         cfg_data
);
    import sbq_pkg::*;

    cmd_t                       cmd;
    logic signed [SAMPLE_W-1:0] left_out, right_out;

    sbq_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .cmd     (cmd)
    );

    sbq_datapath
    #(
        .COEF_WIDTH    (COEF_WIDTH),
        .HISTORY_WIDTH (HISTORY_WIDTH)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .left_in   (s_axis_tdata[SAMPLE_W-1:0]),
        .right_in  (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .left_out  (left_out),
        .right_out (right_out)
    );

    assign m_axis_tdata = {right_out, left_out};

    // Checks on sequencing
`include "assert_macros.svh"

    // A result must never overwrite one that is still waiting.
    `SBQ_ASSERT(a_no_overwrite, cmd.commit && cmd.commit_ch && m_axis_tvalid |-> m_axis_tready, "result overwritten while pending")
    // Committing the right channel makes the pair visible next cycle.
    `SBQ_ASSERT_NEXT(a_commit_valid, cmd.commit && cmd.commit_ch, m_axis_tvalid, "commit did not raise tvalid")
    // The accumulator only starts from a product issued the cycle before.
    `SBQ_ASSERT(a_load_after_mul, cmd.acc_load |-> $past(cmd.mul_en), "accumulator loaded without product")
    // Once an item is taken the sequencer is busy for the next cycle.
    `SBQ_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted on back-to-back cycles")

endmodule
